// ===== hw/rtl/sdp_pkg.sv =====
package sdp_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned OperW    = 2 * DataW;
  localparam int unsigned ProdW    = 3 * DataW;
  localparam int unsigned StepW    = 5;

  localparam logic [DataW-1:0] CfgReset = DataW'(64'd1 << FracBits);

  localparam logic [StepW-1:0] StepAccum = StepW'(15);
  localparam logic [StepW-1:0] StepFinal = StepW'(19);

  typedef enum logic [1:0] {
    CFG_RADIUS_SQUARED = 2'd0,
    CFG_DENSITY_WEIGHT = 2'd1,
    CFG_PRESSURE_GAIN  = 2'd2,
    CFG_REST_DENSITY   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    SEL_A_MAG_X,
    SEL_A_MAG_Y,
    SEL_A_MAG_Z,
    SEL_A_HR2,
    SEL_A_OPER_LO,
    SEL_A_OPER_HI
  } sel_a_e;

  typedef enum logic [2:0] {
    SEL_B_MAG_X,
    SEL_B_MAG_Y,
    SEL_B_MAG_Z,
    SEL_B_HR2,
    SEL_B_WEIGHT,
    SEL_B_GAIN
  } sel_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD_LO,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_HR2,
    LD_OPER,
    LD_TERM,
    LD_EXCESS
  } load_op_e;

  typedef struct packed {
    logic     load_in;
    sel_a_e   sel_a;
    sel_b_e   sel_b;
    acc_op_e  acc_op;
    load_op_e load_op;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } dp_status_t;

endpackage

// ===== hw/rtl/sdp_ctrl.sv =====
module sdp_ctrl
  import sdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepAccum && !status_i.last) begin
          state_d = ST_IDLE;
        end else if (step_q == StepFinal) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // one shared 32x32 multiplier; a product is registered and added in the step after its issue
  always_comb begin
    cmd_o         = '0;
    cmd_o.sel_a   = SEL_A_MAG_X;
    cmd_o.sel_b   = SEL_B_MAG_X;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.load_op = LD_NONE;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_RUN: begin
        unique case (step_q)
          5'd0: begin
            cmd_o.sel_a  = SEL_A_MAG_X;
            cmd_o.sel_b  = SEL_B_MAG_X;
            cmd_o.acc_op = ACC_CLEAR;
          end
          5'd1: begin
            cmd_o.sel_a  = SEL_A_MAG_Y;
            cmd_o.sel_b  = SEL_B_MAG_Y;
            cmd_o.acc_op = ACC_ADD_LO;
          end
          5'd2: begin
            cmd_o.sel_a  = SEL_A_MAG_Z;
            cmd_o.sel_b  = SEL_B_MAG_Z;
            cmd_o.acc_op = ACC_ADD_LO;
          end
          5'd3: cmd_o.acc_op = ACC_ADD_LO;
          5'd4: begin
            cmd_o.load_op = LD_HR2;
            cmd_o.acc_op  = ACC_CLEAR;
          end
          5'd5: begin
            cmd_o.sel_a = SEL_A_HR2;
            cmd_o.sel_b = SEL_B_HR2;
          end
          5'd6: cmd_o.acc_op = ACC_ADD_LO;
          5'd7, 5'd11: begin
            cmd_o.load_op = LD_OPER;
            cmd_o.acc_op  = ACC_CLEAR;
          end
          5'd8: begin
            cmd_o.sel_a = SEL_A_OPER_LO;
            cmd_o.sel_b = SEL_B_HR2;
          end
          5'd9: begin
            cmd_o.sel_a  = SEL_A_OPER_HI;
            cmd_o.sel_b  = SEL_B_HR2;
            cmd_o.acc_op = ACC_ADD_LO;
          end
          5'd10, 5'd14, 5'd19: cmd_o.acc_op = ACC_ADD_HI;
          5'd12: begin
            cmd_o.sel_a = SEL_A_OPER_LO;
            cmd_o.sel_b = SEL_B_WEIGHT;
          end
          5'd13: begin
            cmd_o.sel_a  = SEL_A_OPER_HI;
            cmd_o.sel_b  = SEL_B_WEIGHT;
            cmd_o.acc_op = ACC_ADD_LO;
          end
          5'd15: cmd_o.load_op = LD_TERM;
          5'd16: begin
            cmd_o.load_op = LD_EXCESS;
            cmd_o.acc_op  = ACC_CLEAR;
          end
          5'd17: begin
            cmd_o.sel_a = SEL_A_OPER_LO;
            cmd_o.sel_b = SEL_B_GAIN;
          end
          5'd18: begin
            cmd_o.sel_a  = SEL_A_OPER_HI;
            cmd_o.sel_b  = SEL_B_GAIN;
            cmd_o.acc_op = ACC_ADD_LO;
          end
          default: cmd_o.acc_op = ACC_HOLD;
        endcase
      end
      ST_EMIT: cmd_o.emit = !status_i.out_full;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/sdp_datapath.sv =====
module sdp_datapath
  import sdp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic signed [DataW-1:0] offset_x_i,
  input  logic signed [DataW-1:0] offset_y_i,
  input  logic signed [DataW-1:0] offset_z_i,
  input  logic                    last_neighbour_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [DataW-1:0]        density_o,
  output logic [DataW-1:0]        pressure_o,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o
);

  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] v);
    magnitude = v[DataW-1] ? (~v + DataW'(1)) : v;
  endfunction

  logic [DataW-1:0] radius_q, weight_q, gain_q, rest_q;
  logic [DataW-1:0] mag_x_q, mag_y_q, mag_z_q, hr2_q;
  logic             last_q, in_range_q;
  logic [OperW-1:0] oper_q, mul_q, mul_d;
  logic [ProdW-1:0] prod_q, prod_d, prod_shift;
  logic [AccW-1:0]  acc_q, term, acc_sat, excess;
  logic [AccW:0]    acc_sum;
  logic [OperW-1:0] r2, oper_sat;
  logic [DataW-1:0] opa, opb, density_q, pressure_q, density_sat, pressure_sat;
  logic             out_valid_q, in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= CfgReset;
      weight_q <= CfgReset;
      gain_q   <= CfgReset;
      rest_q   <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_RADIUS_SQUARED: radius_q <= cfg_data_i;
        CFG_DENSITY_WEIGHT: weight_q <= cfg_data_i;
        CFG_PRESSURE_GAIN:  gain_q   <= cfg_data_i;
        CFG_REST_DENSITY:   rest_q   <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.sel_a)
      SEL_A_MAG_X:   opa = mag_x_q;
      SEL_A_MAG_Y:   opa = mag_y_q;
      SEL_A_MAG_Z:   opa = mag_z_q;
      SEL_A_HR2:     opa = hr2_q;
      SEL_A_OPER_LO: opa = oper_q[DataW-1:0];
      SEL_A_OPER_HI: opa = oper_q[OperW-1:DataW];
      default:       opa = '0;
    endcase
    unique case (cmd_i.sel_b)
      SEL_B_MAG_X:  opb = mag_x_q;
      SEL_B_MAG_Y:  opb = mag_y_q;
      SEL_B_MAG_Z:  opb = mag_z_q;
      SEL_B_HR2:    opb = hr2_q;
      SEL_B_WEIGHT: opb = weight_q;
      SEL_B_GAIN:   opb = gain_q;
      default:      opb = '0;
    endcase
  end

  assign mul_d = {{(OperW-DataW){1'b0}}, opa} * {{(OperW-DataW){1'b0}}, opb};

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD:   prod_d = prod_q;
      ACC_CLEAR:  prod_d = '0;
      ACC_ADD_LO: prod_d = prod_q + {{(ProdW-OperW){1'b0}}, mul_q};
      ACC_ADD_HI: prod_d = prod_q + {mul_q, {(ProdW-OperW){1'b0}}};
      default:    prod_d = prod_q;
    endcase
  end

  assign prod_shift = prod_q >> FracBits;
  assign r2         = prod_q[OperW-1:0] >> FracBits;
  assign in_range   = r2 < {{(OperW-DataW){1'b0}}, radius_q};
  assign oper_sat   = (|prod_shift[ProdW-1:OperW]) ? '1 : prod_shift[OperW-1:0];
  assign term       = (|prod_shift[ProdW-1:AccW]) ? '1 : prod_shift[AccW-1:0];
  assign acc_sum    = {1'b0, acc_q} + {1'b0, term};
  assign acc_sat    = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
  assign excess     = (acc_q > {{(AccW-DataW){1'b0}}, rest_q})
                    ? acc_q - {{(AccW-DataW){1'b0}}, rest_q} : '0;
  assign density_sat  = (|acc_q[AccW-1:DataW]) ? '1 : acc_q[DataW-1:0];
  assign pressure_sat = (|prod_shift[ProdW-1:DataW]) ? '1 : prod_shift[DataW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        acc_q <= '0;
      end else if (cmd_i.load_op == LD_TERM && in_range_q) begin
        acc_q <= acc_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q  <= mul_d;
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      mag_x_q <= magnitude(offset_x_i);
      mag_y_q <= magnitude(offset_y_i);
      mag_z_q <= magnitude(offset_z_i);
      last_q  <= last_neighbour_i;
    end
    unique case (cmd_i.load_op)
      LD_HR2: begin
        hr2_q      <= radius_q - r2[DataW-1:0];
        in_range_q <= in_range;
      end
      LD_OPER:   oper_q <= oper_sat;
      LD_EXCESS: oper_q <= {{(OperW-AccW){1'b0}}, excess};
      default:   oper_q <= oper_q;
    endcase
    if (cmd_i.emit) begin
      density_q  <= density_sat;
      pressure_q <= pressure_sat;
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign density_o         = density_q;
  assign pressure_o        = pressure_q;

endmodule

// ===== hw/rtl/sph_density_pressure.sv =====
// Poly6 density and pressure unit. Neighbour offset words of one particle,
// self included, arrive on the input channel; the word flagged last_neighbour
// closes the particle and produces one output word holding the saturated
// density and the pressure gain*(density-rest), clamped at zero. All values are
// Q16.16. One 32x32 multiplier is stepped through the squares, the kernel cube,
// the weight and the pressure product; the input is stalled until a word's steps
// are done, and a last word's result also waits until the previous output word
// has been taken. The output word sits in a register, so a new neighbour word is
// accepted while a result is still stalled. Configuration writes are to be
// made only while no particle is in progress.
module sph_density_pressure
  import sdp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] offset_x_i,
  input  logic signed [DataW-1:0] offset_y_i,
  input  logic signed [DataW-1:0] offset_z_i,
  input  logic                    last_neighbour_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DataW-1:0]        density_o,
  output logic [DataW-1:0]        pressure_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sdp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .offset_x_i       (offset_x_i),
    .offset_y_i       (offset_y_i),
    .offset_z_i       (offset_z_i),
    .last_neighbour_i (last_neighbour_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .density_o        (density_o),
    .pressure_o       (pressure_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

// ===== hw/rtl/sdp_checker.sv =====
module sdp_checker
  import sdp_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [1:0]              cfg_index_i,
  input logic [DataW-1:0]        cfg_data_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [DataW-1:0] offset_x_i,
  input logic signed [DataW-1:0] offset_y_i,
  input logic signed [DataW-1:0] offset_z_i,
  input logic                    last_neighbour_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [DataW-1:0]        density_o,
  input logic [DataW-1:0]        pressure_o
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(density_o) && $stable(pressure_o))
    else $error("output word changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous word in progress");

  // a result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word appeared without work in progress");

  // zero density leaves no excess over rest density
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && density_o == '0 |-> pressure_o == '0)
    else $error("nonzero pressure with zero density");

endmodule

bind sph_density_pressure sdp_checker u_sdp_checker (.*);
